// ----- rtl/ssh_payload_field_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// SSH payload field decoder assertion macros
// Shared property wrappers; each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SSH_PAYLOAD_FIELD_DECODER_ASSERT_SVH
`define SSH_PAYLOAD_FIELD_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define SPFD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset only.
`define SPFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/spfd_pkg.sv -----
// ----------------------------------------------------------------------------
// spfd_pkg
// Types, codes and helpers shared by the payload field decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spfd_pkg;

	localparam int NUM_SLOTS  = 16;
	localparam int MAX_FIELDS = 16;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [1:0] CFG_FIELD_TYPES = 2'd0;
	localparam logic [1:0] CFG_FIELD_COUNT = 2'd1;

	typedef enum logic [2:0] {
		TYPE_STRING   = 3'd0,
		TYPE_MPINT    = 3'd1,
		TYPE_NAMELIST = 3'd2,
		TYPE_BOOL     = 3'd3,
		TYPE_U8       = 3'd4,
		TYPE_U32      = 3'd5,
		TYPE_U64      = 3'd6,
		TYPE_LIST     = 3'd7
	} field_type_e;

	typedef enum logic [1:0] {
		KIND_FIXED   = 2'd0,
		KIND_LEN     = 2'd1,
		KIND_CONTENT = 2'd2,
		KIND_END     = 2'd3
	} rec_kind_e;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

	typedef struct packed {
		rec_kind_e   kind;
		logic [3:0]  idx;
		logic [2:0]  ftype;
		logic [63:0] value;
		logic        clast;
		logic [1:0]  status;
		logic        last;
	} record_t;

	// One accepted byte yields at most a data record and an end record.
	typedef struct packed {
		logic    has_dat;
		logic    has_end;
		record_t dat;
		record_t fin;
	} entry_t;

	// Type code of a schedule slot; slots past the table read as string.
	function automatic logic [2:0] slot_type(input logic [47:0] types, input logic [4:0] idx);
		logic [5:0] base;
		base = 6'(idx[3:0]) * 6'd3;
		if (idx >= 5'(NUM_SLOTS))
			return 3'(TYPE_STRING);
		return types[base +: 3];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ssh_payload_field_decoder.sv -----
// ----------------------------------------------------------------------------
// ssh_payload_field_decoder
// SSH binary payload field decoder: bytes in, typed field records out.
// ----------------------------------------------------------------------------
// The input side is a queue write port: a payload byte and its end flag are
// taken at a rising edge where push is high and full is low. The result side
// is a queue read port: the oldest record sits on the record ports while
// empty is low and is taken at an edge where pop is high. Configuration is a
// separate valid/ready write channel that is always ready; cfg_index selects
// the type schedule (0) or the field count (1), other indexes are ignored.
// A byte's records are queued when the byte is taken and then pass through
// the output register. The block takes one byte per cycle while full is
// low; a byte yields at most two records (a data record and, on the final
// byte, an end record), and the single output register drains one record
// per cycle while pop is high. A four-entry queue between the byte classifier
// and the record unpacker absorbs that. Full rises when the receiver
// stalls long enough to fill the queue, or when short payloads whose final
// bytes each give two records arrive back to back; nothing is lost or repeated
// under a stall. Reset clears the schedule, the field count and all parse
// state, so the block starts on a fresh payload with an empty schedule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssh_payload_field_decoder
	import spfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [47:0] cfg_data,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_payload,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       record_kind,
	output logic [3:0]       field_index,
	output logic [2:0]       field_type,
	output logic [63:0]      value,
	output logic             content_last,
	output logic [1:0]       status,
	output logic             last
);

	entry_t  ent;
	logic    ent_valid;
	logic    accept;
	entry_t  head;
	logic    q_empty;
	logic    q_pop;
	record_t rec;
	logic    rec_valid;

	// Configuration writes land directly in the registers, so the channel never stalls.
	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	spfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.accept    (accept),
		.byte_in   (data_byte),
		.eop_in    (end_of_payload),
		.ent       (ent),
		.ent_valid (ent_valid)
	);

	// Bytes that yield no record are consumed by the front and never queued.
	spfd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ent_valid),
		.wr_data (ent),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (head),
		.empty   (q_empty)
	);

	spfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.rec       (rec),
		.rec_valid (rec_valid),
		.rec_pop   (pop)
	);

	assign empty        = !rec_valid;
	assign record_kind  = rec.kind;
	assign field_index  = rec.idx;
	assign field_type   = rec.ftype;
	assign value        = rec.value;
	assign content_last = rec.clast;
	assign status       = rec.status;
	assign last         = rec.last;

endmodule

`default_nettype wire

// ----- rtl/spfd_front.sv -----
// ----------------------------------------------------------------------------
// spfd_front
// Holds the schedule and the per-payload parse state and classifies each byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spfd_front
	import spfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [47:0] cfg_wdata,
	input  wire logic        accept,
	input  wire logic [7:0]  byte_in,
	input  wire logic        eop_in,
	output entry_t           ent,
	output logic             ent_valid
);

`include "ssh_payload_field_decoder_assert.svh"

	logic [47:0] types_q;
	logic [4:0]  count_q;
	logic [4:0]  slot_q;
	logic [3:0]  bip_q;
	logic [63:0] acc_q;
	logic [31:0] rem_q;
	logic        in_content_q;

	logic [4:0]  lim;
	logic [4:0]  s_eff;
	logic        active;
	logic [2:0]  t;
	logic [63:0] acc_n;
	logic [3:0]  bip_inc;
	logic [3:0]  need;
	logic        lastc;
	logic [4:0]  slot_d;
	logic [3:0]  bip_d;
	logic [63:0] acc_d;
	logic [31:0] rem_d;
	logic        in_content_d;

	assign lim = (count_q > 5'(MAX_FIELDS)) ? 5'(MAX_FIELDS) : count_q;

	// List slots take no bytes: move to the first live slot at or after the current one.
	always_comb begin
		s_eff = (slot_q < lim) ? lim : slot_q;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (5'(i) >= slot_q && 5'(i) < lim && slot_type(types_q, 5'(i)) != 3'(TYPE_LIST))
				s_eff = 5'(i);
		end
	end

	assign active  = s_eff < lim;
	assign t       = slot_type(types_q, s_eff);
	assign acc_n   = {acc_q[55:0], byte_in};
	assign bip_inc = bip_q + 4'd1;
	assign need    = (t == 3'(TYPE_U64)) ? 4'd8 : 4'd4;
	assign lastc   = rem_q <= 32'd1;

	always_comb begin
		slot_d       = s_eff;
		bip_d        = bip_q;
		acc_d        = acc_q;
		rem_d        = rem_q;
		in_content_d = in_content_q;
		ent          = '0;
		ent.dat.idx   = s_eff[3:0];
		ent.dat.ftype = t;
		ent.dat.kind  = KIND_FIXED;
		if (active) begin
			if (in_content_q) begin
				ent.has_dat     = 1'b1;
				ent.dat.kind    = KIND_CONTENT;
				ent.dat.value   = 64'(byte_in);
				ent.dat.clast   = lastc;
				rem_d           = lastc ? 32'd0 : rem_q - 32'd1;
				if (lastc) begin
					in_content_d = 1'b0;
					slot_d       = s_eff + 5'd1;
				end
			end else if (t == 3'(TYPE_BOOL) || t == 3'(TYPE_U8)) begin
				ent.has_dat   = 1'b1;
				ent.dat.value = 64'(byte_in);
				slot_d        = s_eff + 5'd1;
			end else if (bip_inc >= need) begin
				ent.has_dat = 1'b1;
				bip_d       = 4'd0;
				acc_d       = 64'd0;
				if (t == 3'(TYPE_U32) || t == 3'(TYPE_U64)) begin
					ent.dat.value = acc_n;
					slot_d        = s_eff + 5'd1;
				end else begin
					ent.dat.kind  = KIND_LEN;
					ent.dat.value = 64'(acc_n[31:0]);
					if (acc_n[31:0] == 32'd0) begin
						slot_d = s_eff + 5'd1;
					end else begin
						in_content_d = 1'b1;
						rem_d        = acc_n[31:0];
					end
				end
			end else begin
				bip_d = bip_inc;
				acc_d = acc_n;
			end
		end

		// End record reports what the payload left unfinished.
		ent.has_end    = eop_in;
		ent.fin.kind   = KIND_END;
		ent.fin.last   = 1'b1;
		ent.fin.status = STATUS_OK;
		if (in_content_d) begin
			ent.fin.status = STATUS_OVERFLOW;
			ent.fin.value  = 64'(rem_d);
		end else if (bip_d != 4'd0) begin
			ent.fin.status = STATUS_TRUNCATED;
			ent.fin.value  = 64'(bip_d);
		end
		if (ent.fin.status != STATUS_OK) begin
			ent.fin.idx   = slot_d[3:0];
			ent.fin.ftype = slot_type(types_q, slot_d);
		end
	end

	assign ent_valid = accept && (ent.has_dat || ent.has_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			types_q      <= '0;
			count_q      <= '0;
			slot_q       <= '0;
			bip_q        <= '0;
			acc_q        <= '0;
			rem_q        <= '0;
			in_content_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_idx == CFG_FIELD_TYPES)
				types_q <= cfg_wdata;
			if (cfg_we && cfg_idx == CFG_FIELD_COUNT)
				count_q <= cfg_wdata[4:0];
			if (accept) begin
				if (eop_in) begin
					slot_q       <= '0;
					bip_q        <= '0;
					acc_q        <= '0;
					rem_q        <= '0;
					in_content_q <= 1'b0;
				end else begin
					slot_q       <= slot_d;
					bip_q        <= bip_d;
					acc_q        <= acc_d;
					rem_q        <= rem_d;
					in_content_q <= in_content_d;
				end
			end
		end
	end

	`SPFD_ASSERT_IMP(a_content_has_bytes, in_content_q, rem_q != 32'd0, "content phase with zero bytes due")
	`SPFD_ASSERT_IMP(a_part_bound, 1'b1, bip_q < 4'd8, "number byte count out of range")

endmodule

`default_nettype wire

// ----- rtl/spfd_queue.sv -----
// ----------------------------------------------------------------------------
// spfd_queue
// Short queue of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spfd_queue
	import spfd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr_en,
	input  entry_t      wr_data,
	output logic        full,
	input  wire logic   rd_en,
	output entry_t      rd_data,
	output logic        empty
);

`include "ssh_payload_field_decoder_assert.svh"

	entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full    = count_q == QCNT_W'(QDEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (wr_en && !rd_en)
				count_q <= count_q + QCNT_W'(1);
			else if (rd_en && !wr_en)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	`SPFD_ASSERT_IMP(a_no_overflow, wr_en, !full, "queue written while full")
	`SPFD_ASSERT_IMP(a_no_underflow, rd_en, !empty, "queue read while empty")

endmodule

`default_nettype wire

// ----- rtl/spfd_back.sv -----
// ----------------------------------------------------------------------------
// spfd_back
// Unpacks queued entries into single records and holds the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spfd_back
	import spfd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  entry_t    head,
	input  wire logic q_empty,
	output logic      q_pop,
	output record_t   rec,
	output logic      rec_valid,
	input  wire logic rec_pop
);

`include "ssh_payload_field_decoder_assert.svh"

	record_t rec_q;
	logic    valid_q;
	logic    dat_done_q;
	logic    load;
	logic    take;
	logic    use_dat;
	record_t sel;

	assign load    = !valid_q || rec_pop;
	assign take    = load && !q_empty;
	assign use_dat = head.has_dat && !dat_done_q;
	assign sel     = use_dat ? head.dat : head.fin;
	// The entry leaves only once its last record has been taken.
	assign q_pop   = take && !(use_dat && head.has_end);

	assign rec       = rec_q;
	assign rec_valid = valid_q;

	always_ff @(posedge clk) begin
		if (take)
			rec_q <= sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			dat_done_q <= 1'b0;
		end else begin
			if (load)
				valid_q <= !q_empty;
			if (take)
				dat_done_q <= use_dat && head.has_end;
		end
	end

	`SPFD_ASSERT_IMP(a_split_entry_held, dat_done_q, !q_empty, "half-sent entry missing from queue")

endmodule

`default_nettype wire

// ----- sim/ssh_payload_field_decoder_checker.sv -----
// ----------------------------------------------------------------------------
// ssh_payload_field_decoder_checker
// Watches the byte, record and configuration channels of the payload field
// decoder, works out the records each accepted byte must give and compares
// every popped record with the oldest one still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssh_payload_field_decoder_checker
	import spfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_payload,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  record_kind,
	input  logic [3:0]  field_index,
	input  logic [2:0]  field_type,
	input  logic [63:0] value,
	input  logic        content_last,
	input  logic [1:0]  status,
	input  logic        last,
	output int          fail_count,
	output int          pending
);

	// Shadow of the configuration registers.
	logic [47:0] sched_types;
	logic [4:0]  sched_count;

	// Shadow of the parse state.
	logic [4:0]  cur_slot;
	logic [3:0]  num_bytes;
	logic [63:0] shift_acc;
	logic [31:0] remaining;
	logic        content_phase;

	record_t expected_records[$];

	function automatic field_type_e type_of_slot(input logic [4:0] s);
		if (s >= 5'd16)
			return TYPE_STRING;
		return field_type_e'(sched_types[3 * s +: 3]);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch in %s: got %0h, expected %0h", what, got, want);
		fail_count++;
	endtask

	task automatic add_record(input rec_kind_e kind, input logic [4:0] idx,
			input field_type_e ftype, input logic [63:0] val, input logic clast,
			input logic [1:0] st, input logic lst);
		record_t r;
		r.kind   = kind;
		r.idx    = idx[3:0];
		r.ftype  = ftype;
		r.value  = val;
		r.clast  = clast;
		r.status = st;
		r.last   = lst;
		expected_records.push_back(r);
	endtask

	// Decodes one accepted byte and queues the records it must give.
	task automatic decode_byte(input logic [7:0] b, input logic eop);
		logic [4:0]  lim;
		field_type_e t;
		logic [3:0]  need;
		logic        clast;
		logic [31:0] len;
		logic [1:0]  st;
		logic [63:0] v;
		logic [4:0]  idx;
		field_type_e ty;
		lim = (sched_count > 5'd16) ? 5'd16 : sched_count;
		// List slots take no bytes; they are stepped over when a byte arrives.
		while (cur_slot < lim && type_of_slot(cur_slot) == TYPE_LIST)
			cur_slot++;
		if (cur_slot < lim) begin
			t = type_of_slot(cur_slot);
			if (content_phase) begin
				clast = (remaining <= 32'd1);
				add_record(KIND_CONTENT, cur_slot, t, {56'd0, b}, clast, STATUS_OK, 1'b0);
				if (clast) begin
					remaining     = '0;
					content_phase = 1'b0;
					cur_slot++;
				end else begin
					remaining--;
				end
			end else if (t == TYPE_BOOL || t == TYPE_U8) begin
				add_record(KIND_FIXED, cur_slot, t, {56'd0, b}, 1'b0, STATUS_OK, 1'b0);
				cur_slot++;
			end else begin
				need      = (t == TYPE_U64) ? 4'd8 : 4'd4;
				shift_acc = {shift_acc[55:0], b};
				num_bytes++;
				if (num_bytes >= need) begin
					if (t == TYPE_U32 || t == TYPE_U64) begin
						add_record(KIND_FIXED, cur_slot, t, shift_acc, 1'b0, STATUS_OK, 1'b0);
						cur_slot++;
					end else begin
						len = shift_acc[31:0];
						add_record(KIND_LEN, cur_slot, t, {32'd0, len}, 1'b0, STATUS_OK, 1'b0);
						if (len == 32'd0) begin
							cur_slot++;
						end else begin
							content_phase = 1'b1;
							remaining     = len;
						end
					end
					num_bytes = '0;
					shift_acc = '0;
				end
			end
		end
		if (eop) begin
			st  = STATUS_OK;
			v   = '0;
			idx = '0;
			ty  = TYPE_STRING;
			if (content_phase) begin
				st = STATUS_OVERFLOW;
				v  = {32'd0, remaining};
			end else if (num_bytes != 4'd0) begin
				st = STATUS_TRUNCATED;
				v  = {60'd0, num_bytes};
			end
			if (st != STATUS_OK) begin
				idx = cur_slot;
				ty  = type_of_slot(cur_slot);
			end
			add_record(KIND_END, idx, ty, v, 1'b0, st, 1'b1);
			cur_slot      = '0;
			num_bytes     = '0;
			shift_acc     = '0;
			remaining     = '0;
			content_phase = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : observe
		record_t want;
		if (!arst_n) begin
			sched_types   = '0;
			sched_count   = '0;
			cur_slot      = '0;
			num_bytes     = '0;
			shift_acc     = '0;
			remaining     = '0;
			content_phase = 1'b0;
			expected_records.delete();
			fail_count    = 0;
			pending       = 0;
		end else begin
			// A byte taken at this edge is decoded with the settings in force
			// before any write at the same edge.
			if (push && !full)
				decode_byte(data_byte, end_of_payload);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_FIELD_TYPES)
					sched_types = cfg_data;
				else if (cfg_index == CFG_FIELD_COUNT)
					sched_count = cfg_data[4:0];
			end
			if (pop && !empty) begin
				if (expected_records.size() == 0) begin
					report_mismatch("record with nothing expected", value, 64'd0);
				end else begin
					want = expected_records.pop_front();
					if (record_kind != want.kind)
						report_mismatch("record_kind", 64'(record_kind), 64'(want.kind));
					if (field_index != want.idx)
						report_mismatch("field_index", 64'(field_index), 64'(want.idx));
					if (field_type != want.ftype)
						report_mismatch("field_type", 64'(field_type), 64'(want.ftype));
					if (value != want.value)
						report_mismatch("value", value, want.value);
					if (content_last != want.clast)
						report_mismatch("content_last", 64'(content_last), 64'(want.clast));
					if (status != want.status)
						report_mismatch("status", 64'(status), 64'(want.status));
					if (last != want.last)
						report_mismatch("last", 64'(last), 64'(want.last));
				end
			end
			pending = expected_records.size();
		end
	end

endmodule

// ----- sim/ssh_payload_field_decoder_test.sv -----
// ----------------------------------------------------------------------------
// ssh_payload_field_decoder_test
// Drives payload bytes and schedule settings into the field decoder while a
// checker beside it predicts and compares every record it gives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssh_payload_field_decoder_test;
	import spfd_pkg::*;

	// Cycles allowed for the whole run; the slowest correct run needs far less.
	localparam int CYCLE_LIMIT = 200000;
	// Cycles to wait after the last expected record, so that bytes which give
	// no record have certainly left the pipeline.
	localparam int SETTLE_CYCLES = 10;
	// Length of each deliberate receiver hold-off.
	localparam int HOLD_CYCLES = 150;
	// Counted bytes per random phase that decodes data.
	localparam int PHASE_BYTES = 80;

	typedef enum int {
		SHAPE_WELL,
		SHAPE_TRUNC,
		SHAPE_OVER,
		SHAPE_NOISE
	} shape_e;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [47:0] cfg_data;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        end_of_payload;
	logic        empty;
	logic        pop;
	logic [1:0]  record_kind;
	logic [3:0]  field_index;
	logic [2:0]  field_type;
	logic [63:0] value;
	logic        content_last;
	logic [1:0]  status;
	logic        last;
	int          fail_count;
	int          pending;

	// The schedule currently written into the block, used to shape payloads.
	logic [47:0] cur_types;
	logic [4:0]  cur_count;

	// Payload under construction; trail_n counts the ignored bytes at its end.
	logic [7:0]  payload_q[$];
	int          trail_n;

	// Bytes left in the current sender burst.
	int          burst_left;

	// Each increment asks the receiver for one long hold-off.
	int          hold_requests;

	ssh_payload_field_decoder dut (.*);

	ssh_payload_field_decoder_checker record_check (.*);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Random schedule of sixteen 3-bit type codes.
	function automatic logic [47:0] random_types();
		return 48'({$urandom, $urandom});
	endfunction

	// Offers one byte and returns at the falling edge after it was taken.
	// Bursts of random length alternate with random gaps; now and then a
	// burst is long enough to leave a long stretch with no sender idling.
	task automatic feed_byte(input logic [7:0] b, input logic eop);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
		end
		push           <= 1'b1;
		data_byte      <= b;
		end_of_payload <= eop;
		do
			@(posedge clk);
		while (full);
		burst_left--;
		@(negedge clk);
	endtask

	// Sends the bytes in payload_q, with the end flag on the final one.
	task automatic send_payload();
		for (int i = 0; i < payload_q.size(); i++)
			feed_byte(payload_q[i], i == payload_q.size() - 1);
	endtask

	// Stops the sender and waits until every expected record has been taken
	// and the pipeline has had time to swallow bytes that give no record.
	task automatic drain_outputs();
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Holds one register write until the channel takes it. The caller lowers
	// cfg_valid, so that two writes in a row keep it high without a glitch.
	task automatic write_reg(input logic [1:0] idx, input logic [47:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
	endtask

	// Writes both registers, only once the block has gone idle.
	task automatic set_schedule(input logic [47:0] types, input logic [4:0] count);
		drain_outputs();
		write_reg(CFG_FIELD_TYPES, types);
		write_reg(CFG_FIELD_COUNT, {43'd0, count});
		cfg_valid <= 1'b0;
		cur_types = types;
		cur_count = count;
	endtask

	// Number bytes are mostly random, but all-zero and all-one bytes are
	// favored so that the extremes of every number type come up often.
	function automatic logic [7:0] number_byte(input int fill);
		if (fill == 0)
			return 8'h00;
		if (fill == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// Builds one payload for the current schedule. A well-formed payload
	// walks every scheduled field and may carry a few ignored bytes at the
	// end. A truncated payload is a well-formed one cut short, so that the
	// end flag may fall inside a number or a content run. An overflowing one
	// declares a length larger than the content that follows before it ends.
	// Noise is a short run of random bytes.
	task automatic build_payload(input shape_e shape);
		int          lim;
		logic [2:0]  t;
		logic [31:0] len;
		int          nbytes;
		int          fill;
		int          stop;
		int          cut;
		payload_q.delete();
		trail_n = 0;
		stop    = 0;
		if (shape == SHAPE_NOISE) begin
			repeat ($urandom_range(1, 12)) payload_q.push_back(8'($urandom));
			return;
		end
		lim = (cur_count > 5'd16) ? 16 : int'(cur_count);
		for (int s = 0; s < lim && stop == 0; s++) begin
			t    = cur_types[3 * s +: 3];
			fill = $urandom_range(0, 7);
			case (t) inside
				TYPE_LIST: begin
				end
				TYPE_BOOL, TYPE_U8, TYPE_U32, TYPE_U64: begin
					nbytes = (t == TYPE_U64) ? 8 : (t == TYPE_U32) ? 4 : 1;
					repeat (nbytes) payload_q.push_back(number_byte(fill));
				end
				default: begin
					if (shape == SHAPE_OVER) begin
						len = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
							: 32'($urandom_range(4, 400));
						nbytes = $urandom_range(0, 3);
						stop   = 1;
					end else begin
						len = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(7, 24))
							: 32'($urandom_range(0, 6));
						nbytes = int'(len);
					end
					for (int k = 3; k >= 0; k--)
						payload_q.push_back(len[8 * k +: 8]);
					repeat (nbytes) payload_q.push_back(8'($urandom));
				end
			endcase
		end
		if (shape == SHAPE_TRUNC && payload_q.size() > 1) begin
			cut = $urandom_range(1, payload_q.size() - 1);
			while (payload_q.size() > cut)
				void'(payload_q.pop_back());
		end
		if (shape == SHAPE_WELL)
			trail_n = $urandom_range(0, 3);
		// A payload needs at least one byte to carry the end flag.
		if (payload_q.size() == 0 && trail_n == 0)
			trail_n = 1;
		repeat (trail_n) payload_q.push_back(8'($urandom));
	endtask

	// Receiver: pops on a 16-bit mask that is drawn anew each time it runs
	// out, so stalls fall on every phase of the work. Masks range from no
	// stall at all to mostly stalling. On request it holds off for a long
	// stretch, counted here, while the sender keeps offering bytes, so the
	// block fills up and raises full.
	initial begin : receiver
		int          holds_served;
		int          hold_left;
		int          mask_pos;
		logic [15:0] mask;
		holds_served = 0;
		hold_left    = 0;
		mask_pos     = 0;
		mask         = '1;
		pop          = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_requests != holds_served) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (mask_pos == 0) begin
				case ($urandom_range(0, 3))
					0: mask = '1;
					1: mask = 16'($urandom);
					2: mask = 16'($urandom) & 16'($urandom);
					default: mask = 16'($urandom) | 16'($urandom);
				endcase
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= mask[mask_pos];
			end
			mask_pos = (mask_pos + 1) % 16;
		end
	end

	// Watchdog: a run that hangs ends here as a failure.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int     counted;
		int     sent;
		bit     fixed_count;
		shape_e shape;
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		push           = 1'b0;
		data_byte      = '0;
		end_of_payload = 1'b0;
		cur_types      = '0;
		cur_count      = '0;
		burst_left     = 0;
		hold_requests  = 0;
		trail_n        = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part.
		// Out of reset the schedule is empty: a lone byte gives only the end
		// record, with status ok.
		payload_q = '{8'hFF};
		send_payload();

		// Schedule with a u8, a bool, a u64, a string with one content byte, an
		// mpint of zero length and a trailing list slot. The final byte comes
		// after the schedule is exhausted, so it gives only the end record.
		set_schedule({30'd0, TYPE_LIST, TYPE_MPINT, TYPE_STRING, TYPE_U64, TYPE_BOOL,
			TYPE_U8}, 5'd6);
		payload_q = '{8'h00, 8'h01,
			8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF,
			8'h00, 8'h00, 8'h00, 8'h01, 8'h61,
			8'h00, 8'h00, 8'h00, 8'h00,
			8'h5A};
		send_payload();

		// A string whose length runs past the end of the payload, then a
		// payload that ends inside the length prefix.
		set_schedule({42'd0, TYPE_U32, TYPE_STRING}, 5'd2);
		payload_q = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'h7E};
		send_payload();
		payload_q = '{8'h00, 8'h00};
		send_payload();

		// Random part: several schedules, the extremes among them. Phases
		// whose schedule decodes nothing send a fixed handful of payloads.
		for (int p = 0; p < 12; p++) begin
			case (p) inside
				0: set_schedule(random_types(), 5'd16);
				1: set_schedule('0, 5'd16);
				2, 9: set_schedule(random_types(), 5'd31);
				3: set_schedule('1, 5'd16);
				4: set_schedule(random_types(), 5'd0);
				6: set_schedule(random_types(), 5'd1);
				default: set_schedule(random_types(), 5'($urandom_range(1, 16)));
			endcase
			if (p == 0 || p == 5)
				hold_requests <= hold_requests + 1;
			fixed_count = (p == 3 || p == 4);
			counted     = 0;
			sent        = 0;
			while (fixed_count ? (sent < 8) : (counted < PHASE_BYTES && sent < 60)) begin
				case ($urandom_range(0, 9))
					7: shape = SHAPE_TRUNC;
					8: shape = SHAPE_OVER;
					9: shape = SHAPE_NOISE;
					default: shape = SHAPE_WELL;
				endcase
				build_payload(shape);
				counted += payload_q.size() - trail_n;
				send_payload();
				sent++;
			end
		end

		drain_outputs();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- ssh_payload_field_decoder.f -----
+incdir+rtl
rtl/spfd_pkg.sv
rtl/spfd_front.sv
rtl/spfd_queue.sv
rtl/spfd_back.sv
rtl/ssh_payload_field_decoder.sv
sim/ssh_payload_field_decoder_checker.sv
sim/ssh_payload_field_decoder_test.sv
